// ===== design/jst_pkg.sv =====
// Shared types, codes and byte-class functions for the JSON stream tokenizer.
// No dependencies; the top, front and back design files import this package.
`default_nettype none
package jst_pkg;

  localparam int MAX_NEST       = 16;
  localparam int TOKEN_LIMIT    = 256;
  localparam int MAX_TEXT       = 65536;
  localparam int LONGEST_NUMBER = 39;
  localparam int QDEPTH         = 4;
  localparam int RES_MAX        = 3;

  localparam int NEST_W = $clog2(MAX_NEST + 1);
  localparam int SIDX_W = $clog2(MAX_NEST);
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    RK_TOKEN = 2'd0, RK_DONE = 2'd1, RK_ERROR = 2'd2
  } res_kind_t;

  typedef enum logic [1:0] {
    TK_OBJECT = 2'd0, TK_ARRAY = 2'd1, TK_STRING = 2'd2, TK_PRIM = 2'd3
  } tok_kind_t;

  typedef enum logic [1:0] {
    ERR_SYNTAX = 2'd0, ERR_TOKENS = 2'd1, ERR_DEPTH = 2'd2
  } err_code_t;

  typedef enum logic [4:0] {
    M_VALUE, M_ARR_FIRST, M_OBJ_FIRST, M_OBJ_KEY, M_COLON, M_AFTER, M_PRIM,
    M_VSTR, M_VESC, M_VHEX, M_KSTR, M_KESC, M_KHEX
  } mode_t;

  typedef enum logic [3:0] {
    N_START, N_SIGN, N_INT, N_DOT, N_FRAC, N_EXP, N_ESIGN, N_EDIG, N_DEAD
  } num_t;

  // literal matcher: 0 idle/dead, 1..4 true, 5..9 false, 10..13 null
  localparam logic [3:0] LIT_IDLE  = 4'd0;
  localparam logic [3:0] LIT_TRUE  = 4'd1;
  localparam logic [3:0] LIT_FALSE = 4'd5;
  localparam logic [3:0] LIT_NULL  = 4'd10;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  token_index;
    logic [1:0]  token_kind;
    logic [15:0] start_offset;
    logic [16:0] end_offset;
    logic [8:0]  child_count;
    logic [1:0]  error_code;
    logic [8:0]  token_total;
  } result_t;

  typedef struct packed {
    logic [1:0]             count;
    result_t [RES_MAX-1:0]  res;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } q_wr_t;

  typedef struct packed {
    logic [QCNT_W-1:0] fill;
  } back_stat_t;

  typedef struct packed {
    logic [NEST_W-1:0] nest_level;
    logic              err_latched;
  } front_stat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

  function automatic logic in_prim_set(input logic [7:0] c);
    return is_digit(c) || (c == "+") || (c == "-") || (c == ".") || (c == "e") ||
           (c == "E") || (c == "t") || (c == "r") || (c == "u") || (c == "f") ||
           (c == "a") || (c == "l") || (c == "s") || (c == "n");
  endfunction

  function automatic logic in_esc_set(input logic [7:0] c);
    return (c == 8'h22) || (c == 8'h5C) || (c == "/") || (c == "b") || (c == "f") ||
           (c == "n") || (c == "r") || (c == "t");
  endfunction

  function automatic logic [3:0] lit_first(input logic [7:0] c);
    logic [3:0] s;
    s = LIT_IDLE;
    if (c == "t") s = LIT_TRUE;
    else if (c == "f") s = LIT_FALSE;
    else if (c == "n") s = LIT_NULL;
    return s;
  endfunction

  function automatic logic [3:0] lit_next(input logic [3:0] s, input logic [7:0] c);
    logic [7:0] want;
    logic       ok;
    ok = 1'b1;
    want = 8'h00;
    case (s)
      4'd1:    want = "r";
      4'd2:    want = "u";
      4'd3:    want = "e";
      4'd5:    want = "a";
      4'd6:    want = "l";
      4'd7:    want = "s";
      4'd8:    want = "e";
      4'd10:   want = "u";
      4'd11:   want = "l";
      4'd12:   want = "l";
      default: ok = 1'b0;
    endcase
    return (ok && (c == want)) ? s + 4'd1 : LIT_IDLE;
  endfunction

  function automatic logic lit_accept(input logic [3:0] s);
    return (s == 4'd4) || (s == 4'd9) || (s == 4'd13);
  endfunction

  function automatic num_t num_next(input num_t s, input logic [7:0] c);
    logic d, e, sg;
    num_t r;
    d  = is_digit(c);
    e  = (c == "e") || (c == "E");
    sg = (c == "+") || (c == "-");
    case (s)
      N_START:        r = d ? N_INT : ((c == "-") ? N_SIGN : N_DEAD);
      N_SIGN:         r = d ? N_INT : N_DEAD;
      N_INT:          r = d ? N_INT : ((c == ".") ? N_DOT : (e ? N_EXP : N_DEAD));
      N_DOT, N_FRAC:  r = d ? N_FRAC : (e ? N_EXP : N_DEAD);
      N_EXP:          r = d ? N_EDIG : (sg ? N_ESIGN : N_DEAD);
      N_ESIGN, N_EDIG: r = d ? N_EDIG : N_DEAD;
      default:        r = N_DEAD;
    endcase
    return r;
  endfunction

  function automatic logic num_accept(input num_t s);
    return (s == N_INT) || (s == N_DOT) || (s == N_FRAC) || (s == N_EDIG);
  endfunction

  function automatic result_t mk_token(input logic [7:0] slot, input tok_kind_t k,
                                       input logic [15:0] st, input logic [16:0] en,
                                       input logic [8:0] ch);
    result_t r;
    r = '0;
    r.result_kind  = RK_TOKEN;
    r.token_index  = slot;
    r.token_kind   = k;
    r.start_offset = st;
    r.end_offset   = en;
    r.child_count  = ch;
    return r;
  endfunction

  function automatic result_t mk_error(input err_code_t code);
    result_t r;
    r = '0;
    r.result_kind = RK_ERROR;
    r.error_code  = code;
    return r;
  endfunction

  function automatic result_t mk_done(input logic [8:0] total);
    result_t r;
    r = '0;
    r.result_kind = RK_DONE;
    r.token_total = total;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/jst_if.sv =====
// Valid/ready channel interfaces for text items and result items.
// Depends on nothing; payload fields follow the block's item layout.
`default_nettype none
interface jst_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       has_byte;
  logic       end_of_text;
  modport source (output valid, text_byte, has_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, has_byte, end_of_text, output ready);
endinterface

interface jst_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  token_index;
  logic [1:0]  token_kind;
  logic [15:0] start_offset;
  logic [16:0] end_offset;
  logic [8:0]  child_count;
  logic [1:0]  error_code;
  logic [8:0]  token_total;
  logic        last_of_run;
  modport source (output valid, result_kind, token_index, token_kind, start_offset,
                  end_offset, child_count, error_code, token_total, last_of_run,
                  input ready);
  modport sink   (input valid, result_kind, token_index, token_kind, start_offset,
                  end_offset, child_count, error_code, token_total, last_of_run,
                  output ready);
endinterface
`default_nettype wire

// ===== design/json_stream_tokenizer_top.sv =====
// JSON stream tokenizer: one text byte per item, token/finish/error results out.
// Results of an item are pushed as one bundle into the result queue and handed out from it.
// One item per cycle while the queue has room; the k results of an item leave the output in turn,
// and a four-bundle queue absorbs bursts.
// Reset (rst, synchronous): parser rearmed, queue emptied, max_tokens = 256.
// Uses jst_pkg, jst_if, jst_front, jst_back.
`default_nettype none
module json_stream_tokenizer_top
  import jst_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [8:0] cfg_wr_data,
  jst_text_if.sink        text,
  jst_result_if.source    result
);

  q_wr_t       q_wr;
  logic        q_ready;
  front_stat_t fstat;
  back_stat_t  bstat;

  jst_front u_front (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .text(text), .q_ready(q_ready), .q_wr(q_wr), .stat(fstat)
  );

  jst_back u_back (
    .clk(clk), .rst(rst), .q_wr(q_wr), .q_ready(q_ready), .result(result), .stat(bstat)
  );

  a_push_space: assert property (@(posedge clk) disable iff (rst)
    q_wr.valid |-> q_ready) else $error("bundle pushed into full queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    bstat.fill <= QCNT_W'(QDEPTH)) else $error("queue fill over depth");

  a_nest_bound: assert property (@(posedge clk) disable iff (rst)
    fstat.nest_level <= NEST_W'(MAX_NEST)) else $error("nesting over limit");

  a_eot_rearm: assert property (@(posedge clk) disable iff (rst)
    (text.valid && text.ready && text.end_of_text) |=>
      (fstat.nest_level == '0 && !fstat.err_latched))
    else $error("parser not rearmed after end of text");

endmodule
`default_nettype wire

// ===== design/jst_front.sv =====
// Front end: accepts text items, runs the parser state update and nesting stack,
// and pushes the results of each item as one bundle. Uses jst_pkg, jst_if.
`default_nettype none
module jst_front
  import jst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [8:0]  cfg_wr_data,
  jst_text_if.sink         text,
  input  wire logic        q_ready,
  output q_wr_t            q_wr,
  output front_stat_t      stat
);

  logic [8:0]  max_tokens;
  mode_t       mode, mode_next;
  logic [16:0] byte_pos, byte_pos_next;
  logic [8:0]  used, used_next;
  logic [NEST_W-1:0] nest, nest_next;
  logic [15:0] item_start, item_start_next;
  logic [3:0]  lit, lit_next_v;
  num_t        num, num_next_v;
  logic [5:0]  lit_len, lit_len_next;
  logic [2:0]  hex_left, hex_left_next;
  logic        err, err_next;

  // top of stack lives in registers; stk holds the levels below it
  logic        top_obj, top_obj_next;
  logic [7:0]  top_slot, top_slot_next;
  logic [15:0] top_start, top_start_next;
  logic [8:0]  top_child, top_child_next;

  logic        stk_obj   [MAX_NEST];
  logic [7:0]  stk_slot  [MAX_NEST];
  logic [15:0] stk_start [MAX_NEST];
  logic [8:0]  stk_child [MAX_NEST];
  logic              stk_we;
  logic [SIDX_W-1:0] stk_wi, stk_ri;

  logic    acc;
  bundle_t bnd;

  assign acc        = text.valid && text.ready;
  assign text.ready = q_ready;
  assign stk_ri     = SIDX_W'(nest - NEST_W'(2));

  always_comb begin
    logic [7:0]  c;
    logic [16:0] pos;
    logic [8:0]  lim;
    logic [1:0]  cnt;
    logic        cont, key, do_close, do_open, open_obj, do_start, ok;
    c = text.text_byte;
    pos = byte_pos;
    lim = (max_tokens > 9'(TOKEN_LIMIT)) ? 9'(TOKEN_LIMIT) : max_tokens;
    cnt = 2'd0;
    cont = 1'b0;
    key = 1'b0;
    do_close = 1'b0;
    do_open = 1'b0;
    open_obj = 1'b0;
    do_start = 1'b0;
    ok = 1'b0;
    bnd = '0;
    mode_next = mode;
    byte_pos_next = byte_pos;
    used_next = used;
    nest_next = nest;
    item_start_next = item_start;
    lit_next_v = lit;
    num_next_v = num;
    lit_len_next = lit_len;
    hex_left_next = hex_left;
    err_next = err;
    top_obj_next = top_obj;
    top_slot_next = top_slot;
    top_start_next = top_start;
    top_child_next = top_child;
    stk_we = 1'b0;
    stk_wi = SIDX_W'(nest - NEST_W'(1));

    if (acc && text.has_byte && !err) begin
      if (pos >= 17'(MAX_TEXT)) begin
        bnd.res[cnt] = mk_error(ERR_SYNTAX); cnt = cnt + 2'd1; err_next = 1'b1;
      end else begin
        byte_pos_next = pos + 17'd1;
        cont = 1'b1;
        if (mode == M_PRIM) begin
          if (in_prim_set(c)) begin
            lit_next_v = lit_next(lit, c);
            num_next_v = num_next(num, c);
            if (lit_len <= 6'(LONGEST_NUMBER)) lit_len_next = lit_len + 6'd1;
            cont = 1'b0;
          end else begin
            ok = lit_accept(lit) || (num_accept(num) && lit_len <= 6'(LONGEST_NUMBER));
            if (!ok) begin
              bnd.res[cnt] = mk_error(ERR_SYNTAX); cnt = cnt + 2'd1; err_next = 1'b1;
            end else if (used_next >= lim) begin
              bnd.res[cnt] = mk_error(ERR_TOKENS); cnt = cnt + 2'd1; err_next = 1'b1;
            end else begin
              bnd.res[cnt] = mk_token(used_next[7:0], TK_PRIM, item_start, pos, 9'd0);
              cnt = cnt + 2'd1;
              used_next = used_next + 9'd1;
              if (nest != '0) top_child_next = top_child_next + 9'd1;
              mode_next = M_AFTER;
            end
            cont = !err_next;
          end
        end
        if (cont) begin
          key = (mode_next == M_KSTR) || (mode_next == M_KESC) || (mode_next == M_KHEX);
          unique case (mode_next)
            M_VALUE: begin
              if (!is_ws(c)) do_start = 1'b1;
            end
            M_ARR_FIRST: begin
              if (!is_ws(c)) begin
                if (c == "]") do_close = 1'b1;
                else do_start = 1'b1;
              end
            end
            M_OBJ_FIRST, M_OBJ_KEY: begin
              if (!is_ws(c)) begin
                if (c == "}" && mode_next == M_OBJ_FIRST) do_close = 1'b1;
                else if (c == 8'h22) begin
                  item_start_next = 16'(pos + 17'd1);
                  mode_next = M_KSTR;
                end else begin
                  bnd.res[cnt] = mk_error(ERR_SYNTAX); cnt = cnt + 2'd1; err_next = 1'b1;
                end
              end
            end
            M_COLON: begin
              if (!is_ws(c)) begin
                if (c == ":") mode_next = M_VALUE;
                else begin
                  bnd.res[cnt] = mk_error(ERR_SYNTAX); cnt = cnt + 2'd1; err_next = 1'b1;
                end
              end
            end
            M_AFTER: begin
              if (!is_ws(c)) begin
                if (nest == '0) begin
                  bnd.res[cnt] = mk_error(ERR_SYNTAX); cnt = cnt + 2'd1; err_next = 1'b1;
                end else if (c == ",") begin
                  mode_next = top_obj ? M_OBJ_KEY : M_VALUE;
                end else if (c == (top_obj ? 8'h7D : 8'h5D)) begin
                  do_close = 1'b1;
                end else begin
                  bnd.res[cnt] = mk_error(ERR_SYNTAX); cnt = cnt + 2'd1; err_next = 1'b1;
                end
              end
            end
            M_VSTR, M_KSTR: begin
              if (c == 8'h22) begin
                if (used_next >= lim) begin
                  bnd.res[cnt] = mk_error(ERR_TOKENS); cnt = cnt + 2'd1; err_next = 1'b1;
                end else begin
                  bnd.res[cnt] = mk_token(used_next[7:0], TK_STRING, item_start, pos, 9'd0);
                  cnt = cnt + 2'd1;
                  used_next = used_next + 9'd1;
                  if (key) mode_next = M_COLON;
                  else begin
                    if (nest != '0) top_child_next = top_child_next + 9'd1;
                    mode_next = M_AFTER;
                  end
                end
              end else if (c < 8'h20) begin
                bnd.res[cnt] = mk_error(ERR_SYNTAX); cnt = cnt + 2'd1; err_next = 1'b1;
              end else if (c == 8'h5C) begin
                mode_next = key ? M_KESC : M_VESC;
              end
            end
            M_VESC, M_KESC: begin
              if (c == "u") begin
                hex_left_next = 3'd4;
                mode_next = key ? M_KHEX : M_VHEX;
              end else if (in_esc_set(c)) begin
                mode_next = key ? M_KSTR : M_VSTR;
              end else begin
                bnd.res[cnt] = mk_error(ERR_SYNTAX); cnt = cnt + 2'd1; err_next = 1'b1;
              end
            end
            M_VHEX, M_KHEX: begin
              if (!is_hex(c)) begin
                bnd.res[cnt] = mk_error(ERR_SYNTAX); cnt = cnt + 2'd1; err_next = 1'b1;
              end else begin
                if (hex_left != 3'd0) hex_left_next = hex_left - 3'd1;
                if (hex_left_next == 3'd0) mode_next = key ? M_KSTR : M_VSTR;
              end
            end
            default: begin
              bnd.res[cnt] = mk_error(ERR_SYNTAX); cnt = cnt + 2'd1; err_next = 1'b1;
            end
          endcase

          if (do_start) begin
            if (c == "{" || c == "[") begin
              do_open = 1'b1;
              open_obj = (c == "{");
            end else if (c == 8'h22) begin
              item_start_next = 16'(pos + 17'd1);
              mode_next = M_VSTR;
            end else if (in_prim_set(c)) begin
              item_start_next = pos[15:0];
              lit_next_v = lit_first(c);
              num_next_v = num_next(N_START, c);
              lit_len_next = 6'd1;
              mode_next = M_PRIM;
            end else begin
              bnd.res[cnt] = mk_error(ERR_SYNTAX); cnt = cnt + 2'd1; err_next = 1'b1;
            end
          end

          if (do_open) begin
            if (nest >= NEST_W'(MAX_NEST)) begin
              bnd.res[cnt] = mk_error(ERR_DEPTH); cnt = cnt + 2'd1; err_next = 1'b1;
            end else if (used_next >= lim) begin
              bnd.res[cnt] = mk_error(ERR_TOKENS); cnt = cnt + 2'd1; err_next = 1'b1;
            end else begin
              stk_we = (nest != '0);
              top_obj_next = open_obj;
              top_slot_next = used_next[7:0];
              top_start_next = pos[15:0];
              top_child_next = 9'd0;
              used_next = used_next + 9'd1;
              nest_next = nest + NEST_W'(1);
              mode_next = open_obj ? M_OBJ_FIRST : M_ARR_FIRST;
            end
          end

          if (do_close) begin
            if (nest == '0) begin
              bnd.res[cnt] = mk_error(ERR_SYNTAX); cnt = cnt + 2'd1; err_next = 1'b1;
            end else begin
              bnd.res[cnt] = mk_token(top_slot, top_obj ? TK_OBJECT : TK_ARRAY, top_start,
                                      pos + 17'd1, top_child_next);
              cnt = cnt + 2'd1;
              nest_next = nest - NEST_W'(1);
              if (nest_next != '0) begin
                top_obj_next = stk_obj[stk_ri];
                top_slot_next = stk_slot[stk_ri];
                top_start_next = stk_start[stk_ri];
                top_child_next = stk_child[stk_ri] + 9'd1;
              end
              mode_next = M_AFTER;
            end
          end
        end
      end
    end

    if (acc && text.end_of_text) begin
      if (!err_next) begin
        cont = 1'b1;
        if (mode_next == M_PRIM) begin
          ok = lit_accept(lit_next_v) ||
               (num_accept(num_next_v) && lit_len_next <= 6'(LONGEST_NUMBER));
          if (!ok) begin
            bnd.res[cnt] = mk_error(ERR_SYNTAX); cnt = cnt + 2'd1; cont = 1'b0;
          end else if (used_next >= lim) begin
            bnd.res[cnt] = mk_error(ERR_TOKENS); cnt = cnt + 2'd1; cont = 1'b0;
          end else begin
            bnd.res[cnt] = mk_token(used_next[7:0], TK_PRIM, item_start_next,
                                    byte_pos_next, 9'd0);
            cnt = cnt + 2'd1;
            used_next = used_next + 9'd1;
            mode_next = M_AFTER;
          end
        end
        if (cont) begin
          if (mode_next == M_AFTER && nest_next == '0) bnd.res[cnt] = mk_done(used_next);
          else bnd.res[cnt] = mk_error(ERR_SYNTAX);
          cnt = cnt + 2'd1;
        end
      end
      mode_next = M_VALUE;
      byte_pos_next = '0;
      used_next = '0;
      nest_next = '0;
      item_start_next = '0;
      lit_next_v = LIT_IDLE;
      num_next_v = N_START;
      lit_len_next = '0;
      hex_left_next = '0;
      err_next = 1'b0;
    end

    bnd.count = cnt;
  end

  assign q_wr.valid  = acc && (bnd.count != 2'd0);
  assign q_wr.bundle = bnd;
  assign stat.nest_level  = nest;
  assign stat.err_latched = err;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_tokens <= 9'd256;
      mode <= M_VALUE;
      byte_pos <= '0;
      used <= '0;
      nest <= '0;
      item_start <= '0;
      lit <= LIT_IDLE;
      num <= N_START;
      lit_len <= '0;
      hex_left <= '0;
      err <= 1'b0;
    end else begin
      if (cfg_wr_en) max_tokens <= cfg_wr_data;
      mode <= mode_next;
      byte_pos <= byte_pos_next;
      used <= used_next;
      nest <= nest_next;
      item_start <= item_start_next;
      lit <= lit_next_v;
      num <= num_next_v;
      lit_len <= lit_len_next;
      hex_left <= hex_left_next;
      err <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    top_obj <= top_obj_next;
    top_slot <= top_slot_next;
    top_start <= top_start_next;
    top_child <= top_child_next;
    if (stk_we) begin
      stk_obj[stk_wi] <= top_obj;
      stk_slot[stk_wi] <= top_slot;
      stk_start[stk_wi] <= top_start;
      stk_child[stk_wi] <= top_child;
    end
  end

endmodule
`default_nettype wire

// ===== design/jst_back.sv =====
// Back end: bundle queue between parser and output, and a serializer that hands
// out the results of each bundle one per cycle while the output is ready. Uses jst_pkg, jst_if.
`default_nettype none
module jst_back
  import jst_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire q_wr_t  q_wr,
  output logic        q_ready,
  jst_result_if.source result,
  output back_stat_t  stat
);

  bundle_t           q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic [1:0]        sub;
  logic              pop, last;
  result_t           r;

  assign q_ready = (fill != QCNT_W'(QDEPTH));
  assign r       = q[rd_ptr].res[sub];
  assign last    = (sub == q[rd_ptr].count - 2'd1);
  assign pop     = result.valid && result.ready && last;

  assign result.valid        = (fill != '0);
  assign result.result_kind  = r.result_kind;
  assign result.token_index  = r.token_index;
  assign result.token_kind   = r.token_kind;
  assign result.start_offset = r.start_offset;
  assign result.end_offset   = r.end_offset;
  assign result.child_count  = r.child_count;
  assign result.error_code   = r.error_code;
  assign result.token_total  = r.token_total;
  assign result.last_of_run  = last;
  assign stat.fill           = fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
      sub <= '0;
    end else begin
      if (q_wr.valid) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (result.valid && result.ready) begin
        if (last) begin
          rd_ptr <= rd_ptr + QPTR_W'(1);
          sub <= '0;
        end else begin
          sub <= sub + 2'd1;
        end
      end
      fill <= fill + QCNT_W'(q_wr.valid) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.valid) q[wr_ptr] <= q_wr.bundle;
  end

endmodule
`default_nettype wire
